[sv/slcan_pkg.sv]
// Shared types, character codes and hex decode for the ASCII CAN frame parser.
package slcan_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ID_W    = 29;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned NIB_CNT = DATA_W / 4;

  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_EXT = 8'h54;  // 'T'
  localparam logic [CHAR_W-1:0] CH_STD = 8'h74;  // 't'
  localparam logic [CHAR_W-1:0] CH_0   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LA  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LFH = 8'h66;  // 'f'

  localparam logic [POS_W-1:0] POS_MAX    = 5'd31;
  localparam logic [POS_W-1:0] ID_DIG_STD = 5'd3;
  localparam logic [POS_W-1:0] ID_DIG_EXT = 5'd8;
  localparam logic [LEN_W-1:0] LEN_MAX    = 4'd8;
  localparam logic [4:0]       HEX_BAD    = 5'd16;

  typedef struct packed {
    logic              extended;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
    logic              error;
  } frame_t;

  // Nibble value, or HEX_BAD for a non-hex character.
  function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [4:0] v;
    v = HEX_BAD;
    if (c >= CH_0 && c <= CH_9) begin
      v = 5'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = 5'(c - CH_UA + 8'd10);
    end else if (c >= CH_LA && c <= CH_LFH) begin
      v = 5'(c - CH_LA + 8'd10);
    end
    return v;
  endfunction

endpackage

[sv/slcan_parse.sv]
// Frame state registers and the per-character update.
module slcan_parse import slcan_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [CHAR_W-1:0] char_code,
  output logic              emit,
  output frame_t            frame
);

  logic              in_frame_r, in_frame_nxt;
  logic              ext_r, ext_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic              err_r, err_nxt;

  logic [4:0]       hv;
  logic             bad;
  logic [3:0]       v4;
  logic [POS_W-1:0] id_dig;
  logic [POS_W-1:0] d;
  logic [3:0]       byte_ix;
  logic [3:0]       nib_ix;
  logic             is_open, is_close;

  assign hv       = hex_value(char_code);
  assign bad      = hv[4];
  assign v4       = bad ? 4'd0 : hv[3:0];
  assign id_dig   = ext_r ? ID_DIG_EXT : ID_DIG_STD;
  assign d        = pos_r - id_dig - 5'd1;
  assign byte_ix  = d[4:1];
  assign nib_ix   = {d[3:1], ~d[0]};   // high nibble of a byte comes first
  assign is_open  = (char_code == CH_EXT) || (char_code == CH_STD);
  assign is_close = (char_code == CH_CR) || (char_code == CH_LF);

  assign emit  = is_close && in_frame_r;
  assign frame = '{extended: ext_r, id: id_r, length: len_r, data: data_r, error: err_r};

  always_comb begin
    in_frame_nxt = in_frame_r;
    ext_nxt      = ext_r;
    pos_nxt      = pos_r;
    id_nxt       = id_r;
    len_nxt      = len_r;
    data_nxt     = data_r;
    err_nxt      = err_r;
    if (is_open || is_close) begin
      // start or end of a frame: clear the fields; in_frame and ext follow the character
      in_frame_nxt = is_open;
      ext_nxt      = (char_code == CH_EXT);
      pos_nxt      = '0;
      id_nxt       = '0;
      len_nxt      = '0;
      data_nxt     = '0;
      err_nxt      = 1'b0;
    end else if (in_frame_r && pos_r != POS_MAX) begin
      pos_nxt = pos_r + 5'd1;
      if (pos_r < id_dig) begin
        id_nxt = {id_r[ID_W-5:0], v4};
        if (bad) begin
          err_nxt = 1'b1;
        end
      end else if (pos_r == id_dig) begin
        if (bad) begin
          err_nxt = 1'b1;
          len_nxt = '0;
        end else if (hv[3:0] > LEN_MAX) begin
          err_nxt = 1'b1;
          len_nxt = LEN_MAX;
        end else begin
          len_nxt = hv[3:0];
        end
      end else if (byte_ix < len_r) begin
        if (bad) begin
          err_nxt = 1'b1;
        end
        for (int i = 0; i < NIB_CNT; i++) begin
          if (nib_ix == 4'(i)) begin
            data_nxt[4*i +: 4] = data_r[4*i +: 4] | v4;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      ext_r      <= 1'b0;
      pos_r      <= '0;
      id_r       <= '0;
      len_r      <= '0;
      data_r     <= '0;
      err_r      <= 1'b0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      ext_r      <= ext_nxt;
      pos_r      <= pos_nxt;
      id_r       <= id_nxt;
      len_r      <= len_nxt;
      data_r     <= data_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

[sv/slcan_outbuf.sv]
// Result register holding one finished frame until the sink takes it.
module slcan_outbuf import slcan_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  frame_t frame_in,
  input  logic   take,
  output logic   valid,
  output frame_t frame_out
);

  logic   valid_r, valid_nxt;
  frame_t frame_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= frame_in;
    end
  end

  assign valid     = valid_r;
  assign frame_out = frame_r;

endmodule

[sv/slcan_ascii_frame_parser_core.sv]
// Top level of the ASCII CAN frame parser: input register, parser, result register.
//
// Takes one ASCII character per item on the in_ stream and emits one CAN frame
// on the out_ stream for each CR or LF that closes an open frame. 't' opens a
// standard frame (3 identifier digits), 'T' an extended one (8 digits); then
// one length digit (above 8 saturates to 8 and flags an error) and two hex
// digits per data byte, high nibble first, either case. A non-hex digit flags
// an error and counts as zero; digits past the length are ignored; a new opener
// drops a partial frame; a line end with no open frame emits nothing. Rate: one
// character per cycle while not stalled. Each character is held in the input
// register and the parser state is updated from it when it is processed; a
// character that closes an open frame also loads the result register. out_tvalid
// rises once that character has passed through the input register into the
// result register. The input side stalls only while a character is held and the
// result register is still full and not being taken.
module slcan_ascii_frame_parser_core import slcan_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] char_code
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,   // [28:0] frame_id, [32:29] frame_length,
                                    // [96:33] frame_data, [103:97] zero
  output logic [1:0]   out_tuser    // [0] frame_extended, [1] frame_error
);

  logic              in_vld_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              adv;       // held character is processed this cycle
  logic              emit;
  logic              load;
  frame_t            frame_cur;
  frame_t            frame_out;

  // a character may be processed when the result register has room
  assign adv       = in_vld_r && (!out_tvalid || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign load      = adv && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
    end
  end

  slcan_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .char_code (in_char_r),
    .emit      (emit),
    .frame     (frame_cur)
  );

  slcan_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .frame_in  (frame_cur),
    .take      (out_tready),
    .valid     (out_tvalid),
    .frame_out (frame_out)
  );

  assign out_tdata = {7'd0, frame_out.data, frame_out.length, frame_out.id};
  assign out_tuser = {frame_out.error, frame_out.extended};

  // a finished frame always lands in the result register
  a_load_lands: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid)
    else $error("loaded frame not valid at output");

  // never overwrite a frame the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !load)
    else $error("result register overwritten");

  // length code never exceeds 8
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> frame_out.length <= LEN_MAX)
    else $error("frame length above 8");

  // bytes beyond the length are zero
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (frame_out.data >> {frame_out.length, 3'b000}) == '0)
    else $error("data beyond length not zero");

endmodule
